@@ rtl/core/gicp_pkg.sv @@
// gicp_pkg: shared types, codes and helpers of the grid ic(0) preconditioner
// no dependencies; imported by every module of the block
package gicp_pkg;

    localparam int DATA_W = 32;
    localparam int COORD_W = 6;

    localparam logic [1:0] FUNC_MATRIX = 2'd0;
    localparam logic [1:0] FUNC_RHS    = 2'd1;
    localparam logic [1:0] FUNC_SOLVE  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] center_coef;
        logic signed [DATA_W-1:0] right_coef;
        logic signed [DATA_W-1:0] up_coef;
        logic signed [DATA_W-1:0] rhs_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] solution_value;
        logic [COORD_W-1:0]       cell_col;
        logic [COORD_W-1:0]       cell_row;
        logic                     last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_INIT, ST_TERM, ST_MUL1, ST_MW1, ST_MUL2, ST_MW2,
        ST_SUB, ST_TAIL, ST_DIV, ST_FMUL, ST_FW, ST_FWR
    } t_state;

    typedef enum logic [1:0] {ADDR_CUR, ADDR_LEFT, ADDR_UP} t_addr_sel;
    typedef enum logic [1:0] {OPA_RIGHT, OPA_UP, OPA_MRES, OPA_ACC} t_opa;
    typedef enum logic [2:0] {
        OPB_RIGHT, OPB_UP, OPB_DIAG, OPB_FWD, OPB_PREV, OPB_LINE
    } t_opb;

    typedef struct packed {
        logic [1:0] func;
        logic       latch;
        logic       rd_en;
        t_addr_sel  addr_sel;
        logic       mul_go;
        t_opa       mul_a;
        t_opb       mul_b;
        logic       acc_init;
        logic       acc_sub;
        logic       wr_coef;
        logic       div_start;
        logic       wr_diag;
        logic       wr_fwd;
        logic       wr_sol;
        logic       advance;
    } t_dp_cmd;

    typedef struct packed {
        logic col_gt0;
        logic row_gt0;
        logic col_not_last;
        logic row_not_last;
        logic div_done;
    } t_dp_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'(Q_MAX)) r = Q_MAX;
        else if (v < 64'(Q_MIN)) r = Q_MIN;
        else r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/grid_incomplete_cholesky_precond_unit.sv @@
// grid_incomplete_cholesky_precond_unit: top level of the ic(0) preconditioner
// depends on gicp_pkg, gicp_ctrl, gicp_dp (and gicp_div below it)
//
// command channel: an item is taken when start is high and busy is low;
//   i_item.func picks matrix cell load, rhs cell load or emit of the next
//   solution cell (reverse raster order); func 3 is taken and dropped
// result channel: o_result_valid pulses one cycle with o_result, in the cycle
//   busy drops; the receiver cannot stall, each result is shown once
// config channel: i_cfg_valid/o_cfg_ready, index 0 width, 1 height; a write to
//   either restarts all three raster positions; ready only while no item is in work
// sequencing: one item at a time through one multiplier and accumulator
//   matrix load: each neighbor term is two multiplies and a subtract, then the
//   item waits on the bit-serial reciprocal unit (2*FRAC_BITS+1 steps)
//   rhs load and emit: each neighbor term is one multiply and a subtract
// reset: synchronous active-low; grid 64 x 64 (clamped to MAX_*), load
//   positions at the first cell, emit at the last; stores are not cleared
module grid_incomplete_cholesky_precond_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gicp_pkg::t_in_item   i_item,
    output logic                 o_result_valid,
    output gicp_pkg::t_out_item  o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data
);
    import gicp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_we;

    // config only lands while the sequencer is idle
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    gicp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gicp_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

@@ rtl/core/gicp_div.sv @@
// gicp_div: restoring reciprocal unit, 2^(2*frac) / den, one quotient bit a cycle
// depends on gicp_pkg
module gicp_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [gicp_pkg::DATA_W-1:0] i_den,
    output logic                           o_done,
    output logic signed [gicp_pkg::DATA_W-1:0] o_quot
);
    import gicp_pkg::*;

    localparam int NB = 2 * FRAC_BITS + 1;
    localparam int CNW = $clog2(NB + 1);

    logic [31:0]    r_mag;
    logic [32:0]    r_rem;
    logic [NB-1:0]  r_q;
    logic [CNW-1:0] r_cnt;
    logic           r_neg;
    logic           r_zero;
    logic           r_done;
    logic signed [DATA_W-1:0] r_res;

    logic [32:0]    trial;
    logic           qbit;
    logic [32:0]    n_rem;
    logic [NB-1:0]  n_q;
    logic [63:0]    q64;
    logic signed [DATA_W-1:0] n_res;

    always_comb begin
        // numerator has a single one at bit 2*frac, i.e. the first step
        trial = {r_rem[31:0], (r_cnt == CNW'(NB))};
        qbit  = (trial >= {1'b0, r_mag});
        n_rem = qbit ? (trial - {1'b0, r_mag}) : trial;
        n_q   = {r_q[NB-2:0], qbit};
        q64   = 64'(n_q);
        if (r_zero) begin
            n_res = '0;
        end else if (!r_neg) begin
            n_res = (q64 > 64'h7FFF_FFFF) ? Q_MAX : $signed(q64[31:0]);
        end else begin
            n_res = (q64 > 64'h8000_0000) ? Q_MIN : $signed(32'(-q64[31:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNW'(NB);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNW'(1);
            r_done <= (r_cnt == CNW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_mag  <= i_den[DATA_W-1] ? 32'(-i_den) : 32'(i_den);
            r_neg  <= i_den[DATA_W-1];
            r_zero <= (i_den == '0);
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            if (r_cnt == CNW'(1)) begin
                r_res <= n_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

@@ rtl/core/gicp_dp.sv @@
// gicp_dp: cell stores, positions, multiplier, accumulator and output register
// depends on gicp_pkg and gicp_div
module gicp_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gicp_pkg::t_dp_cmd    i_cmd,
    input  gicp_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    output gicp_pkg::t_dp_stat   o_stat,
    output logic                 o_result_valid,
    output gicp_pkg::t_out_item  o_result
);
    import gicp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW;
    localparam int DEPTH = 2 ** AW;
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (EW > 7) ? EW : 7;
    localparam int XH = (EH > 7) ? EH : 7;
    localparam int RST_W = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
    localparam int RST_H = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

    logic signed [DATA_W-1:0] right_mem [DEPTH];
    logic signed [DATA_W-1:0] up_mem    [DEPTH];
    logic signed [DATA_W-1:0] diag_mem  [DEPTH];
    logic signed [DATA_W-1:0] fwd_mem   [DEPTH];
    logic signed [DATA_W-1:0] line_mem  [MAX_WIDTH];

    logic [6:0] r_grid_w, r_grid_h;
    logic [CW-1:0] r_ld_col, r_rh_col, r_em_col;
    logic [RW-1:0] r_ld_row, r_rh_row, r_em_row;
    t_in_item r_in;
    logic signed [DATA_W-1:0] r_rd_right, r_rd_up, r_rd_diag, r_rd_fwd, r_rd_line;
    logic signed [63:0] r_prod;
    logic signed [DATA_W-1:0] r_mres, r_acc, r_prev;
    logic r_out_valid;
    t_out_item r_out;

    logic [EW-1:0] eff_w, new_w;
    logic [EH-1:0] eff_h, new_h;
    logic [CW-1:0] cur_col, nx_col, pv_col;
    logic [RW-1:0] cur_row, nx_row, pv_row;
    logic [AW-1:0] addr;
    logic signed [DATA_W-1:0] opa, opb, div_q;
    logic div_done;
    logic restart;

    function automatic logic [EW-1:0] clamp_w(input logic [6:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        if (x == '0) return EW'(1);
        if (x > XW'(MAX_WIDTH)) return EW'(MAX_WIDTH);
        return EW'(x);
    endfunction

    function automatic logic [EH-1:0] clamp_h(input logic [6:0] v);
        logic [XH-1:0] x;
        x = XH'(v);
        if (x == '0) return EH'(1);
        if (x > XH'(MAX_HEIGHT)) return EH'(MAX_HEIGHT);
        return EH'(x);
    endfunction

    always_comb begin
        eff_w = clamp_w(r_grid_w);
        eff_h = clamp_h(r_grid_h);
        new_w = clamp_w((i_cfg_index == REG_WIDTH) ? i_cfg_data : r_grid_w);
        new_h = clamp_h((i_cfg_index == REG_HEIGHT) ? i_cfg_data : r_grid_h);
        restart = i_cfg_we && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);
    end

    // position of the item in work
    always_comb begin
        unique case (i_cmd.func)
            FUNC_MATRIX: begin cur_col = r_ld_col; cur_row = r_ld_row; end
            FUNC_RHS:    begin cur_col = r_rh_col; cur_row = r_rh_row; end
            default:     begin cur_col = r_em_col; cur_row = r_em_row; end
        endcase
        unique case (i_cmd.addr_sel)
            ADDR_LEFT: addr = {cur_row, cur_col - CW'(1)};
            ADDR_UP:   addr = {cur_row - RW'(1), cur_col};
            default:   addr = {cur_row, cur_col};
        endcase
        // raster step forward and backward
        if (EW'(cur_col) + EW'(1) == eff_w) begin
            nx_col = '0;
            nx_row = (EH'(cur_row) + EH'(1) == eff_h) ? '0 : cur_row + RW'(1);
        end else begin
            nx_col = cur_col + CW'(1);
            nx_row = cur_row;
        end
        if (cur_col == '0) begin
            pv_col = CW'(eff_w - EW'(1));
            pv_row = (cur_row == '0) ? RW'(eff_h - EH'(1)) : cur_row - RW'(1);
        end else begin
            pv_col = cur_col - CW'(1);
            pv_row = cur_row;
        end
    end

    assign o_stat.col_gt0      = (cur_col != '0);
    assign o_stat.row_gt0      = (cur_row != '0);
    assign o_stat.col_not_last = (EW'(cur_col) + EW'(1)) < eff_w;
    assign o_stat.row_not_last = (EH'(cur_row) + EH'(1)) < eff_h;
    assign o_stat.div_done     = div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= 7'd64;
            r_grid_h <= 7'd64;
            r_ld_col <= '0; r_ld_row <= '0;
            r_rh_col <= '0; r_rh_row <= '0;
            r_em_col <= CW'(RST_W - 1);
            r_em_row <= RW'(RST_H - 1);
        end else if (restart) begin
            if (i_cfg_index == REG_WIDTH) r_grid_w <= i_cfg_data;
            else r_grid_h <= i_cfg_data;
            r_ld_col <= '0; r_ld_row <= '0;
            r_rh_col <= '0; r_rh_row <= '0;
            r_em_col <= CW'(new_w - EW'(1));
            r_em_row <= RW'(new_h - EH'(1));
        end else if (i_cmd.advance) begin
            unique case (i_cmd.func)
                FUNC_MATRIX: begin r_ld_col <= nx_col; r_ld_row <= nx_row; end
                FUNC_RHS:    begin r_rh_col <= nx_col; r_rh_row <= nx_row; end
                default:     begin r_em_col <= pv_col; r_em_row <= pv_row; end
            endcase
        end
    end

    // cell stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef) begin
            right_mem[addr] <= r_in.right_coef;
            up_mem[addr]    <= r_in.up_coef;
        end
        if (i_cmd.wr_diag) diag_mem[addr] <= div_q;
        if (i_cmd.wr_fwd) fwd_mem[addr] <= r_mres;
        if (i_cmd.wr_sol) line_mem[cur_col] <= r_mres;
        if (i_cmd.rd_en) begin
            r_rd_right <= right_mem[addr];
            r_rd_up    <= up_mem[addr];
            r_rd_diag  <= diag_mem[addr];
            r_rd_fwd   <= fwd_mem[addr];
            r_rd_line  <= line_mem[cur_col];
        end
    end

    always_comb begin
        unique case (i_cmd.mul_a)
            OPA_RIGHT: opa = r_rd_right;
            OPA_UP:    opa = r_rd_up;
            OPA_MRES:  opa = r_mres;
            default:   opa = r_acc;
        endcase
        unique case (i_cmd.mul_b)
            OPB_RIGHT: opb = r_rd_right;
            OPB_UP:    opb = r_rd_up;
            OPB_DIAG:  opb = r_rd_diag;
            OPB_FWD:   opb = r_rd_fwd;
            OPB_PREV:  opb = r_prev;
            default:   opb = r_rd_line;
        endcase
    end

    // product, then floor shift and saturation in the cycle after
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_in <= i_item;
        if (i_cmd.mul_go) r_prod <= 64'(opa) * 64'(opb);
        r_mres <= sat32(r_prod >>> FRAC_BITS);
        if (i_cmd.acc_init) begin
            unique case (i_cmd.func)
                FUNC_MATRIX: r_acc <= r_in.center_coef;
                FUNC_RHS:    r_acc <= r_in.rhs_value;
                default:     r_acc <= r_rd_fwd;
            endcase
        end else if (i_cmd.acc_sub) begin
            r_acc <= sat32(64'(r_acc) - 64'(r_mres));
        end
        if (i_cmd.wr_sol) begin
            r_out.solution_value <= r_mres;
            r_out.cell_col       <= COORD_W'(cur_col);
            r_out.cell_row       <= COORD_W'(cur_row);
            r_out.last           <= (cur_col == '0) && (cur_row == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.wr_sol;
            if (i_cmd.wr_sol) r_prev <= r_mres;
        end
    end

    gicp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_den   (r_acc),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

@@ rtl/core/gicp_ctrl.sv @@
// gicp_ctrl: sequencer for matrix load, forward and backward substitution
// depends on gicp_pkg
module gicp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_func,
    input  gicp_pkg::t_dp_stat i_stat,
    output gicp_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import gicp_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_func, n_func;
    logic       r_term, n_term;
    logic       term_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_func  <= FUNC_MATRIX;
            r_term  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
            r_term  <= n_term;
        end
    end

    // whether the current neighbor term contributes
    always_comb begin
        if (r_func == FUNC_SOLVE)
            term_en = r_term ? i_stat.row_not_last : i_stat.col_not_last;
        else
            term_en = r_term ? i_stat.row_gt0 : i_stat.col_gt0;
    end

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_term  = r_term;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_func != 2'd3) begin
                    n_state = ST_START;
                    n_func  = i_func;
                    n_term  = 1'b0;
                end
            end
            ST_START: n_state = ST_INIT;
            ST_INIT:  n_state = ST_TERM;
            ST_TERM: begin
                if (term_en) n_state = ST_MUL1;
                else if (r_term) n_state = ST_TAIL;
                else n_term = 1'b1;
            end
            ST_MUL1: n_state = ST_MW1;
            ST_MW1:  n_state = (r_func == FUNC_MATRIX) ? ST_MUL2 : ST_SUB;
            ST_MUL2: n_state = ST_MW2;
            ST_MW2:  n_state = ST_SUB;
            ST_SUB: begin
                if (r_term) n_state = ST_TAIL;
                else begin
                    n_state = ST_TERM;
                    n_term  = 1'b1;
                end
            end
            ST_TAIL: n_state = (r_func == FUNC_MATRIX) ? ST_DIV : ST_FMUL;
            ST_DIV:  if (i_stat.div_done) n_state = ST_IDLE;
            ST_FMUL: n_state = ST_FW;
            ST_FW:   n_state = ST_FWR;
            ST_FWR:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.func     = r_func;
        o_cmd.addr_sel = ADDR_CUR;
        o_cmd.mul_a    = r_term ? OPA_UP : OPA_RIGHT;
        o_cmd.mul_b    = OPB_DIAG;
        unique case (r_state)
            ST_IDLE:  o_cmd.latch = i_start;
            ST_START: o_cmd.rd_en = 1'b1;
            ST_INIT:  o_cmd.acc_init = 1'b1;
            ST_TERM: begin
                o_cmd.rd_en = term_en;
                if (r_func != FUNC_SOLVE)
                    o_cmd.addr_sel = r_term ? ADDR_UP : ADDR_LEFT;
            end
            ST_MUL1: begin
                o_cmd.mul_go = 1'b1;
                unique case (r_func)
                    FUNC_MATRIX: o_cmd.mul_b = r_term ? OPB_UP : OPB_RIGHT;
                    FUNC_RHS:    o_cmd.mul_b = OPB_FWD;
                    default:     o_cmd.mul_b = r_term ? OPB_LINE : OPB_PREV;
                endcase
            end
            ST_MUL2: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_a  = OPA_MRES;
            end
            ST_SUB: o_cmd.acc_sub = 1'b1;
            ST_TAIL: begin
                if (r_func == FUNC_MATRIX) begin
                    o_cmd.wr_coef   = 1'b1;
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.wr_diag = i_stat.div_done;
                o_cmd.advance = i_stat.div_done;
            end
            ST_FMUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_a  = OPA_ACC;
            end
            ST_FWR: begin
                o_cmd.wr_fwd  = (r_func == FUNC_RHS);
                o_cmd.wr_sol  = (r_func == FUNC_SOLVE);
                o_cmd.advance = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

@@ rtl/core/gicp_check.sv @@
// gicp_check: port-level assertions on the preconditioner, bound to the top level
// depends on gicp_pkg and grid_incomplete_cholesky_precond_unit
module gicp_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input gicp_pkg::t_in_item  i_item,
    input logic                o_result_valid,
    input gicp_pkg::t_out_item o_result,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready
);
    import gicp_pkg::*;

    // a real command occupies the block
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func != 2'd3) |=> busy)
        else $error("command taken but block not busy");

    // unused func is dropped without work
    a_nop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == 2'd3) |=> !busy)
        else $error("unused func started work");

    // a result closes an item that was in work
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(busy)))
        else $error("result without finished item");

    // the last flag marks the origin cell only
    a_last_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |->
            (o_result.cell_col == '0 && o_result.cell_row == '0))
        else $error("last flag off the origin cell");

endmodule

bind grid_incomplete_cholesky_precond_unit gicp_check u_check (.*);
